### rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_SAME(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b in the cycle after
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### rtl/core/ipcls_pkg.sv
// types and constants of the ipv4 port classifier
`timescale 1ns / 1ps
package ipcls_pkg;
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KEY_W = 56;
  localparam int ENTRY_W = KEY_W + 1;

  localparam logic [1:0] REQ_BYTE   = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] PARSE_OK          = 2'd0;
  localparam logic [1:0] PARSE_SHORT       = 2'd1;
  localparam logic [1:0] PARSE_UNSUPPORTED = 2'd2;

  localparam logic [1:0] OP_DONE      = 2'd0;
  localparam logic [1:0] OP_FULL      = 2'd1;
  localparam logic [1:0] OP_NOT_FOUND = 2'd2;
  localparam logic [1:0] OP_PRESENT   = 2'd3;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_SCTP = 8'd132;

  localparam logic [5:0] COUNT_MAX   = 6'd40;
  localparam logic [5:0] LEN_IP_MIN  = 6'd20;
  localparam logic [5:0] LEN_TCP_MIN = 6'd40;
  localparam logic [5:0] LEN_UDP_MIN = 6'd28;
  localparam logic [5:0] LEN_SCTP_MIN = 6'd32;

  localparam logic [5:0] POS_PROTO    = 6'd9;
  localparam logic [5:0] POS_IP_FIRST = 6'd16;
  localparam logic [5:0] POS_IP_LAST  = 6'd19;
  localparam logic [5:0] POS_PORT_HI  = 6'd22;
  localparam logic [5:0] POS_PORT_LO  = 6'd23;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  proto;
  } key_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } entry_t;

  typedef struct packed {
    logic vld;
    logic go;
    logic last;
    idx_t addr;
    key_t key;
  } scan_t;

  typedef struct packed {
    logic done;
    logic found;
    idx_t found_idx;
    logic free_found;
    idx_t free_idx;
  } cell_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_OUT
  } state_t;
endpackage

### rtl/core/ipcls_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface ipcls_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  byte_value;
  logic        last_byte;
  logic        table_select;
  logic [31:0] entry_ip;
  logic [15:0] entry_port;
  logic [7:0]  entry_protocol;
  modport source(output valid, req_type, byte_value, last_byte, table_select,
                 entry_ip, entry_port, entry_protocol, input ready);
  modport sink(input valid, req_type, byte_value, last_byte, table_select,
               entry_ip, entry_port, entry_protocol, output ready);
endinterface

interface ipcls_rsp_if;
  logic       valid;
  logic       ready;
  logic       verdict_valid;
  logic       accept_hit;
  logic       reject_hit;
  logic [1:0] parse_status;
  logic [1:0] op_status;
  modport source(output valid, verdict_valid, accept_hit, reject_hit, parse_status,
                 op_status, input ready);
  modport sink(input valid, verdict_valid, accept_hit, reject_hit, parse_status,
               op_status, output ready);
endinterface

### rtl/core/ipcls_ram.sv
// generic single-write, registered-read ram
`timescale 1ns / 1ps
module ipcls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/ipcls_match_cell.sv
// one table cell: holds a table, compares the passing key, hands the sweep on
`timescale 1ns / 1ps
module ipcls_match_cell import ipcls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  scan_t     scan_in,
  output scan_t     scan_out,
  input  logic      we,
  input  idx_t      waddr,
  input  entry_t    wdata,
  output cell_res_t res
);
  scan_t     s1;
  entry_t    rd;
  logic [ENTRY_W-1:0] rd_raw;
  cell_res_t res_next;
  logic      hit, free, base_found, base_free;
  idx_t      base_found_idx, base_free_idx;

  ipcls_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_in.addr),
    .rdata (rd_raw)
  );

  assign rd = entry_t'(rd_raw);
  assign scan_out = s1;

  always_comb begin
    hit = s1.vld && rd.valid && (rd.key == s1.key);
    free = s1.vld && !rd.valid;
    base_found = s1.go ? 1'b0 : res.found;
    base_free = s1.go ? 1'b0 : res.free_found;
    base_found_idx = res.found_idx;
    base_free_idx = res.free_idx;
    res_next.done = s1.vld && s1.last;
    res_next.found = base_found | hit;
    res_next.found_idx = (!base_found && hit) ? s1.addr : base_found_idx;
    // lowest free slot wins
    res_next.free_found = base_free | free;
    res_next.free_idx = (!base_free && free) ? s1.addr : base_free_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      res <= '0;
    end else begin
      s1 <= scan_in;
      res <= res_next;
    end
  end
endmodule

### rtl/core/ipv4_port_accept_reject_classifier.sv
// top level of the ipv4 destination accept/reject classifier
// channel | dir | transfer moves
// req     | in  | packet byte, or insert/remove of an accept/reject table entry
// rsp     | out | packet verdict or entry status, one per last byte or entry op
// a non-last packet byte leaves the controller idle and ready for the next byte
// a last byte or entry op sweeps both tables in a two-cell chain, one ram read
//   per cell per cycle; a verdict that fails parsing skips the sweep and goes
//   straight to the output state
// after reset a clearing pass over every slot zeroes both tables; no
//   request is taken meanwhile
// a stalled response holds in the output register; the next request is still
//   taken and waits only when its own result is ready
`timescale 1ns / 1ps
module ipv4_port_accept_reject_classifier import ipcls_pkg::*; (
  input logic       clk,
  input logic       rst,
  ipcls_req_if.sink req,
  ipcls_rsp_if.source rsp
);
  localparam idx_t LAST_IDX = idx_t'(TABLE_ENTRIES - 1);

  state_t state, state_next;
  idx_t   addr;

  // packet capture
  logic [5:0]  byte_count;
  logic [7:0]  held_protocol;
  logic [31:0] held_dest_ip;
  logic [15:0] held_dest_port;
  logic [5:0]  cnt_next;
  logic [7:0]  proto_next;
  logic [31:0] ip_next;
  logic [15:0] port_next;
  logic [5:0]  need_len;
  logic [1:0]  parse_next;

  // pending operation and result
  key_t       key;
  logic       op_insert;
  logic       op_table;
  logic       r_verdict, r_acc, r_rej;
  logic [1:0] r_parse, r_op;

  // output register
  logic       o_valid, o_verdict, o_acc, o_rej;
  logic [1:0] o_parse, o_op;

  // cell chain
  scan_t     scan0, scan1, scan_end;
  cell_res_t res0, res1, sel_res;
  logic      we0, we1;
  idx_t      waddr;
  entry_t    wdata;

  logic accept, out_free, sweep_done;

  assign accept = req.valid && req.ready;
  assign out_free = !o_valid || rsp.ready;
  assign sweep_done = res1.done;
  assign sel_res = op_table ? res1 : res0;

  ipcls_match_cell u_cell_accept (
    .clk (clk), .rst (rst), .scan_in (scan0), .scan_out (scan1),
    .we (we0), .waddr (waddr), .wdata (wdata), .res (res0)
  );

  // the reject cell sees each slot of the sweep in the cycle after the accept cell does
  ipcls_match_cell u_cell_reject (
    .clk (clk), .rst (rst), .scan_in (scan1), .scan_out (scan_end),
    .we (we1), .waddr (waddr), .wdata (wdata), .res (res1)
  );

  // byte capture with this byte applied
  always_comb begin
    proto_next = held_protocol;
    ip_next = held_dest_ip;
    port_next = held_dest_port;
    if (byte_count == POS_PROTO) begin
      proto_next = req.byte_value;
    end else if (byte_count >= POS_IP_FIRST && byte_count <= POS_IP_LAST) begin
      ip_next = {held_dest_ip[23:0], req.byte_value};
    end else if (byte_count == POS_PORT_HI || byte_count == POS_PORT_LO) begin
      port_next = {held_dest_port[7:0], req.byte_value};
    end
    cnt_next = (byte_count < COUNT_MAX) ? byte_count + 6'd1 : byte_count;
    case (proto_next)
      PROTO_TCP:  need_len = LEN_TCP_MIN;
      PROTO_UDP:  need_len = LEN_UDP_MIN;
      PROTO_SCTP: need_len = LEN_SCTP_MIN;
      default:    need_len = 6'd0;
    endcase
    if (cnt_next < LEN_IP_MIN) begin
      parse_next = PARSE_SHORT;
    end else if (need_len == 6'd0) begin
      parse_next = PARSE_UNSUPPORTED;
    end else if (cnt_next < need_len) begin
      parse_next = PARSE_SHORT;
    end else begin
      parse_next = PARSE_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (addr == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_BYTE) begin
            if (req.last_byte) state_next = (parse_next == PARSE_OK) ? ST_SCAN : ST_OUT;
          end else if (req.req_type == REQ_INSERT || req.req_type == REQ_REMOVE) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (addr == LAST_IDX) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (sweep_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs of the controller
  always_comb begin
    req.ready = (state == ST_IDLE);
    scan0.vld = (state == ST_SCAN);
    // only the first slot of a real sweep restarts the cell results
    scan0.go = (state == ST_SCAN) && (addr == '0);
    scan0.last = (addr == LAST_IDX);
    scan0.addr = addr;
    scan0.key = key;
    we0 = 1'b0;
    we1 = 1'b0;
    waddr = addr;
    wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        we0 = 1'b1;
        we1 = 1'b1;
      end
      ST_WAIT: begin
        if (sweep_done && !r_verdict) begin
          if (op_insert) begin
            waddr = sel_res.free_idx;
            wdata = {1'b1, key};
            if (!sel_res.found && sel_res.free_found) begin
              we0 = !op_table;
              we1 = op_table;
            end
          end else begin
            // removal clears the valid bit of the matching slot
            waddr = sel_res.found_idx;
            if (sel_res.found) begin
              we0 = !op_table;
              we1 = op_table;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr <= '0;
      byte_count <= '0;
      held_protocol <= '0;
      held_dest_ip <= '0;
      held_dest_port <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_CLEAR || state == ST_SCAN) && addr != LAST_IDX) begin
        addr <= addr + idx_t'(1);
      end else begin
        addr <= '0;
      end
      if (accept && req.req_type == REQ_BYTE) begin
        if (req.last_byte) begin
          byte_count <= '0;
          held_protocol <= '0;
          held_dest_ip <= '0;
          held_dest_port <= '0;
        end else begin
          byte_count <= cnt_next;
          held_protocol <= proto_next;
          held_dest_ip <= ip_next;
          held_dest_port <= port_next;
        end
      end
      if (state == ST_OUT && out_free) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.req_type == REQ_BYTE) begin
        r_verdict <= 1'b1;
        r_parse <= parse_next;
        key <= '{ip: ip_next, port: port_next, proto: proto_next};
      end else begin
        r_verdict <= 1'b0;
        r_parse <= PARSE_OK;
        key <= '{ip: req.entry_ip, port: req.entry_port, proto: req.entry_protocol};
      end
      r_acc <= 1'b0;
      r_rej <= 1'b0;
      r_op <= OP_DONE;
      op_insert <= (req.req_type == REQ_INSERT);
      op_table <= req.table_select;
    end else if (state == ST_WAIT && sweep_done) begin
      if (r_verdict) begin
        r_acc <= res0.found;
        r_rej <= res1.found;
      end else if (op_insert) begin
        if (sel_res.found) r_op <= OP_PRESENT;
        else if (!sel_res.free_found) r_op <= OP_FULL;
        else r_op <= OP_DONE;
      end else begin
        r_op <= sel_res.found ? OP_DONE : OP_NOT_FOUND;
      end
    end
    if (state == ST_OUT && out_free) begin
      o_verdict <= r_verdict;
      o_acc <= r_acc;
      o_rej <= r_rej;
      o_parse <= r_parse;
      o_op <= r_op;
    end
  end

  assign rsp.valid = o_valid;
  assign rsp.verdict_valid = o_verdict;
  assign rsp.accept_hit = o_acc;
  assign rsp.reject_hit = o_rej;
  assign rsp.parse_status = o_parse;
  assign rsp.op_status = o_op;

`include "assert_macros.svh"

  // tables are never written while a sweep reads them
  `ASSERT_SAME(a_no_write_in_scan, state == ST_SCAN, !we0 && !we1)
  // the end of a sweep is only seen while the controller waits for it
  `ASSERT_SAME(a_done_in_wait, sweep_done, state == ST_WAIT)
  // the byte counter saturates
  `ASSERT_SAME(a_count_sat, 1'b1, byte_count <= COUNT_MAX)
  // a sweep always runs into the wait state
  `ASSERT_NEXT(a_scan_to_wait, state == ST_SCAN && addr == LAST_IDX, state == ST_WAIT)
  // the tail of the chain only carries a sweep while one is running
  `ASSERT_SAME(a_sweep_tail, scan_end.vld, state == ST_SCAN || state == ST_WAIT)
endmodule
